FILE: src/cbs_edf_pkg.sv
package cbs_edf_pkg;

	localparam int ID_W    = 4;
	localparam int ORDER_W = 32;
	localparam int ACT_W   = 2;
	localparam int STAT_W  = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_ENQ  = 2'd0,
		ACT_DEQ  = 2'd1,
		ACT_TICK = 2'd2
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_OCC  = 2'd1,
		STAT_NOTQ = 2'd2
	} status_t;

	typedef struct packed {
		logic clear;
		logic en;
		logic slot_vld;
	} pick_ctrl_t;

endpackage

FILE: src/cbs_edf_slot_mem.sv
module cbs_edf_slot_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/cbs_edf_pick.sv
module cbs_edf_pick #(
	parameter int TIME_BITS = 32,
	parameter int IDX_W     = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbs_edf_pkg::pick_ctrl_t             ctrl,
	input  logic [IDX_W-1:0]                    idx,
	input  logic [TIME_BITS-1:0]                cand_dl,
	input  logic [cbs_edf_pkg::ORDER_W-1:0]     cand_ord,
	output logic                                have,
	output logic [IDX_W-1:0]                    best_idx,
	output logic [TIME_BITS-1:0]                best_dl
);

	import cbs_edf_pkg::*;

	logic                 have_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [TIME_BITS-1:0] best_dl_q;
	logic [ORDER_W-1:0]   best_ord_q;
	logic [TIME_BITS-1:0] dl_diff;
	logic [ORDER_W-1:0]   ord_diff;
	logic                 ahead;
	logic                 take;

	// wrap-safe ordering: deadline first, then insertion order
	always_comb begin
		dl_diff  = cand_dl - best_dl_q;
		ord_diff = cand_ord - best_ord_q;
		ahead    = (dl_diff != '0) ? dl_diff[TIME_BITS-1] : ord_diff[ORDER_W-1];
		take     = ctrl.en && ctrl.slot_vld && (!have_q || ahead);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctrl.clear) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= idx;
			best_dl_q  <= cand_dl;
			best_ord_q <= cand_ord;
		end
	end

	assign have     = have_q;
	assign best_idx = best_idx_q;
	assign best_dl  = best_dl_q;

endmodule

FILE: src/cbs_edf_task_scheduler_unit.sv
// EDF task table with constant bandwidth server budgets.
// Input stream: s_tuser carries the action (enqueue, dequeue, tick), s_tdata the
// slot id and the enqueue parameters. Each input transaction yields exactly one
// output transaction: earliest-deadline task, budget of the addressed slot, a
// refill flag and a status code.
// Slot parameters live in one single-port-write synchronous RAM; deadlines are
// held as absolute times against a tick count that steps on each tick of a
// queued slot, so a tick touches only the running slot and the count.
// One transaction at a time, in steps: accept, read-modify-write of the slot,
// sweep of all NUM_TASKS entries through the RAM read port, final compare,
// output load. The sweep reads the RAM one entry a cycle.
// The next input is taken as soon as the result sits in the output register,
// so a stalled receiver holds only the one finished result; a second result
// waits in the load step until m_tready frees the register.
// Reset clears the queued flags, the tick count and the insertion counter;
// the RAM needs no clearing as free slots are never read for results.
module cbs_edf_task_scheduler_unit #(
	parameter int NUM_TASKS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// task_id, deadline, max_budget, period, budget_left
	input  logic [((cbs_edf_pkg::ID_W + 4*TIME_BITS + 7) / 8)*8-1:0] s_tdata,
	// action
	input  logic [cbs_edf_pkg::ACT_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// next_task, next_deadline, budget_now
	output logic [((cbs_edf_pkg::ID_W + 2*TIME_BITS + 7) / 8)*8-1:0] m_tdata,
	// found, replenished, status
	output logic [cbs_edf_pkg::STAT_W+1:0] m_tuser
);

	import cbs_edf_pkg::*;

	localparam int IDX_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int OFS_DL  = 0;
	localparam int OFS_BUD = TIME_BITS;
	localparam int OFS_MAX = 2*TIME_BITS;
	localparam int OFS_PER = 3*TIME_BITS;
	localparam int OFS_ORD = 4*TIME_BITS;
	localparam int ENT_W   = 4*TIME_BITS + ORDER_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [NUM_TASKS-1:0]    slot_valid_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [ORDER_W-1:0]      order_q;
	logic [IDX_W-1:0]        sweep_q;
	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    repl_q;
	logic [TIME_BITS-1:0]    bnow_q;
	status_t                 stat_q;
	logic                    m_tvalid_q;
	logic                    found_q;
	logic [ID_W-1:0]         next_task_q;
	logic [TIME_BITS-1:0]    next_dl_q;
	logic                    m_repl_q;
	logic [TIME_BITS-1:0]    m_bnow_q;
	status_t                 m_stat_q;

	action_t                 act_q;
	logic [ID_W-1:0]         id_q;
	logic [TIME_BITS-1:0]    dl_q;
	logic [TIME_BITS-1:0]    max_q;
	logic [TIME_BITS-1:0]    per_q;
	logic [TIME_BITS-1:0]    bl_q;

	logic                    accept;
	logic [IDX_W-1:0]        slot;
	logic                    in_range;
	logic                    queued;
	logic                    mem_we;
	logic [ENT_W-1:0]        mem_wdata;
	logic [IDX_W-1:0]        mem_raddr;
	logic [ENT_W-1:0]        mem_rdata;
	logic [TIME_BITS-1:0]    bud_dec;
	logic                    set_vld;
	logic                    clr_vld;
	logic                    adv_now;
	logic                    adv_order;
	logic                    repl_d;
	logic [TIME_BITS-1:0]    bnow_d;
	status_t                 stat_d;
	pick_ctrl_t              pick_ctrl;
	logic                    have;
	logic [IDX_W-1:0]        best_idx;
	logic [TIME_BITS-1:0]    best_dl;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign slot     = IDX_W'(id_q);
	assign in_range = int'(id_q) < NUM_TASKS;
	assign queued   = in_range && slot_valid_q[slot];

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(s_tuser);
			id_q  <= s_tdata[ID_W-1:0];
			dl_q  <= s_tdata[ID_W +: TIME_BITS];
			max_q <= s_tdata[ID_W + TIME_BITS +: TIME_BITS];
			per_q <= s_tdata[ID_W + 2*TIME_BITS +: TIME_BITS];
			bl_q  <= s_tdata[ID_W + 3*TIME_BITS +: TIME_BITS];
		end
	end

	assign mem_raddr = (state_q == ST_IDLE) ? IDX_W'(s_tdata[ID_W-1:0]) : sweep_q;

	cbs_edf_slot_mem #(
		.DEPTH (NUM_TASKS),
		.WIDTH (ENT_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// read-modify-write of the addressed slot
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = mem_rdata;
		set_vld   = 1'b0;
		clr_vld   = 1'b0;
		adv_now   = 1'b0;
		adv_order = 1'b0;
		repl_d    = 1'b0;
		bnow_d    = '0;
		stat_d    = STAT_NOTQ;
		bud_dec   = mem_rdata[OFS_BUD +: TIME_BITS] - 1'b1;
		unique case (act_q)
			ACT_ENQ: begin
				if (queued) begin
					stat_d = STAT_OCC;
					bnow_d = mem_rdata[OFS_BUD +: TIME_BITS];
				end else if (in_range) begin
					mem_we                        = 1'b1;
					mem_wdata[OFS_DL  +: TIME_BITS] = dl_q + now_q;
					mem_wdata[OFS_BUD +: TIME_BITS] = bl_q;
					mem_wdata[OFS_MAX +: TIME_BITS] = max_q;
					mem_wdata[OFS_PER +: TIME_BITS] = per_q;
					mem_wdata[OFS_ORD +: ORDER_W]   = order_q;
					set_vld                       = 1'b1;
					adv_order                     = 1'b1;
					stat_d                        = STAT_OK;
					bnow_d                        = bl_q;
				end
			end
			ACT_DEQ: begin
				if (queued) begin
					clr_vld = 1'b1;
					stat_d  = STAT_OK;
					bnow_d  = mem_rdata[OFS_BUD +: TIME_BITS];
				end
			end
			ACT_TICK: begin
				if (queued) begin
					mem_we  = 1'b1;
					adv_now = 1'b1;
					stat_d  = STAT_OK;
					if (bud_dec == '0) begin
						mem_wdata[OFS_DL +: TIME_BITS] = mem_rdata[OFS_DL +: TIME_BITS]
							+ mem_rdata[OFS_PER +: TIME_BITS];
						mem_wdata[OFS_BUD +: TIME_BITS] = mem_rdata[OFS_MAX +: TIME_BITS];
						mem_wdata[OFS_ORD +: ORDER_W]   = order_q;
						adv_order                       = 1'b1;
						repl_d                          = 1'b1;
						bnow_d                          = mem_rdata[OFS_MAX +: TIME_BITS];
					end else begin
						mem_wdata[OFS_BUD +: TIME_BITS] = bud_dec;
						bnow_d                          = bud_dec;
					end
				end
			end
			default: begin
			end
		endcase
		if (state_q != ST_EXEC) begin
			mem_we    = 1'b0;
			set_vld   = 1'b0;
			clr_vld   = 1'b0;
			adv_now   = 1'b0;
			adv_order = 1'b0;
		end
	end

	always_comb begin
		pick_ctrl.clear    = (state_q == ST_EXEC);
		pick_ctrl.en       = rd_vld_s1;
		pick_ctrl.slot_vld = slot_valid_q[rd_idx_s1];
	end

	cbs_edf_pick #(
		.TIME_BITS (TIME_BITS),
		.IDX_W     (IDX_W)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (pick_ctrl),
		.idx      (rd_idx_s1),
		.cand_dl  (mem_rdata[OFS_DL +: TIME_BITS]),
		.cand_ord (mem_rdata[OFS_ORD +: ORDER_W]),
		.have     (have),
		.best_idx (best_idx),
		.best_dl  (best_dl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_valid_q <= '0;
			now_q        <= '0;
			order_q      <= '0;
			sweep_q      <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			repl_q       <= 1'b0;
			bnow_q       <= '0;
			stat_q       <= STAT_OK;
			m_tvalid_q   <= 1'b0;
			found_q      <= 1'b0;
			next_task_q  <= '0;
			next_dl_q    <= '0;
			m_repl_q     <= 1'b0;
			m_bnow_q     <= '0;
			m_stat_q     <= STAT_OK;
		end else begin
			rd_vld_s1 <= (state_q == ST_SWEEP);
			rd_idx_s1 <= sweep_q;
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (set_vld) begin
						slot_valid_q[slot] <= 1'b1;
					end
					if (clr_vld) begin
						slot_valid_q[slot] <= 1'b0;
					end
					if (adv_now) begin
						now_q <= now_q + 1'b1;
					end
					if (adv_order) begin
						order_q <= order_q + 1'b1;
					end
					repl_q  <= repl_d;
					bnow_q  <= bnow_d;
					stat_q  <= stat_d;
					sweep_q <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == IDX_W'(NUM_TASKS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q  <= 1'b1;
						found_q     <= have;
						next_task_q <= have ? ID_W'(best_idx) : '0;
						next_dl_q   <= have ? (best_dl - now_q) : '0;
						m_repl_q    <= repl_q;
						m_bnow_q    <= bnow_q;
						m_stat_q    <= stat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		m_tdata                                = '0;
		m_tdata[ID_W-1:0]                      = next_task_q;
		m_tdata[ID_W +: TIME_BITS]             = next_dl_q;
		m_tdata[ID_W + TIME_BITS +: TIME_BITS] = m_bnow_q;
		m_tuser                                = {m_stat_q, m_repl_q, found_q};
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second transaction taken while one is in flight");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[ID_W-1:0] == '0)
		else $error("task reported with empty table");

	a_refill_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[STAT_W+1:2] == STAT_OK)
		else $error("refill reported on a failed action");

	a_valid_step: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) <= $past($countones(slot_valid_q)) + 1)
		else $error("more than one slot queued in one cycle");

endmodule
